// File: hw/rtl/hrt_pkg.sv
// hrt_pkg: shared constants, token kind codes and the result word type
// for the http request header tokenizer; no dependencies
package hrt_pkg;

  // delimiter characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // request line items
  localparam logic [1:0] ITEM_METHOD  = 2'd0;
  localparam logic [1:0] ITEM_URI     = 2'd1;
  localparam logic [1:0] ITEM_VERSION = 2'd2;
  localparam logic [1:0] ITEM_DROP    = 2'd3;

  // crlf match progress codes
  localparam logic [1:0] PROG_NONE = 2'd0;
  localparam logic [1:0] PROG_CR2  = 2'd2;
  localparam logic [1:0] PROG_LF2  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_METHOD  = 3'd1,
    KIND_URI     = 3'd2,
    KIND_VERSION = 3'd3,
    KIND_KEY     = 3'd4,
    KIND_VALUE   = 3'd5
  } hrt_kind_t;

  // one tagged output word
  typedef struct packed {
    hrt_kind_t  kind;
    logic [7:0] data;
    logic       line_end;
    logic       pair_end;
    logic       header_end;
  } hrt_res_t;

endpackage

// File: hw/rtl/hrt_in_reg.sv
// hrt_in_reg: input register stage holding one request byte
// standalone apart from the hrt_pkg import
module hrt_in_reg
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       advance,
  output logic       valid,
  output logic [7:0] data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;

  // slot frees when empty or when its word moves on this cycle
  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

// File: hw/rtl/hrt_parse.sv
// hrt_parse: tokenizer state and per-byte tagging logic
// depends on hrt_pkg for character constants, kind codes and hrt_res_t
module hrt_parse
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] data,
  output hrt_res_t   res
);

  logic       in_hdr_r, in_hdr_nxt;
  logic [1:0] prog_r, prog_nxt;
  logic [1:0] item_r, item_nxt;
  logic       rd_key_r, rd_key_nxt;
  logic       val_st_r, val_st_nxt;
  logic [7:0] exp_delim;
  logic       is_delim;

  // even progress waits for cr, odd for lf
  assign exp_delim = prog_r[0] ? CH_LF : CH_CR;
  assign is_delim  = (data == exp_delim);

  // next state and tag for the byte in the input register
  always_comb begin
    in_hdr_nxt     = in_hdr_r;
    prog_nxt       = prog_r;
    item_nxt       = item_r;
    rd_key_nxt     = rd_key_r;
    val_st_nxt     = val_st_r;
    res.kind       = KIND_NONE;
    res.data       = data;
    res.line_end   = 1'b0;
    res.pair_end   = 1'b0;
    res.header_end = 1'b0;
    if (!in_hdr_r) begin
      // request line
      if (is_delim) begin
        if (prog_r[0]) begin
          res.line_end = 1'b1;
          in_hdr_nxt   = 1'b1;
          prog_nxt     = PROG_CR2;
          rd_key_nxt   = 1'b1;
          val_st_nxt   = 1'b0;
        end else begin
          prog_nxt = prog_r + 2'd1;
        end
      end else begin
        prog_nxt = PROG_NONE;
        if (data == CH_SP) begin
          if (item_r != ITEM_DROP) begin
            item_nxt = item_r + 2'd1;
          end
        end else begin
          case (item_r)
            ITEM_METHOD:  res.kind = KIND_METHOD;
            ITEM_URI:     res.kind = KIND_URI;
            ITEM_VERSION: res.kind = KIND_VERSION;
            default:      res.kind = KIND_NONE;
          endcase
        end
      end
    end else begin
      // header lines
      if (is_delim) begin
        if (prog_r == PROG_NONE) begin
          res.pair_end = 1'b1;
          rd_key_nxt   = 1'b1;
          val_st_nxt   = 1'b0;
        end
        if (prog_r == PROG_LF2) begin
          res.header_end = 1'b1;
          in_hdr_nxt     = 1'b0;
          prog_nxt       = PROG_NONE;
          item_nxt       = ITEM_METHOD;
          rd_key_nxt     = 1'b1;
          val_st_nxt     = 1'b0;
        end else begin
          prog_nxt = prog_r + 2'd1;
        end
      end else begin
        prog_nxt = PROG_NONE;
        if (rd_key_r && data == CH_COLON) begin
          rd_key_nxt = 1'b0;
        end else if (rd_key_r) begin
          res.kind = KIND_KEY;
        end else if (!val_st_r && data == CH_SP) begin
          res.kind = KIND_NONE;
        end else begin
          val_st_nxt = 1'b1;
          res.kind   = KIND_VALUE;
        end
      end
    end
  end

  // state advances only when the word moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r <= 1'b0;
      prog_r   <= PROG_NONE;
      item_r   <= ITEM_METHOD;
      rd_key_r <= 1'b1;
      val_st_r <= 1'b0;
    end else if (advance) begin
      in_hdr_r <= in_hdr_nxt;
      prog_r   <= prog_nxt;
      item_r   <= item_nxt;
      rd_key_r <= rd_key_nxt;
      val_st_r <= val_st_nxt;
    end
  end

endmodule

// File: hw/rtl/hrt_out_reg.sv
// hrt_out_reg: result register driving the output stream
// depends on hrt_pkg for hrt_res_t
module hrt_out_reg
  import hrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  hrt_res_t res,
  input  logic     out_tready,
  output logic     out_tvalid,
  output hrt_res_t res_q
);

  logic     valid_r, valid_nxt;
  hrt_res_t res_r;

  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign res_q      = res_r;

endmodule

// File: hw/rtl/http_request_header_tokenizer.sv
// http_request_header_tokenizer: tags each request byte with its header part
// path: input register, then result register, with combinational tagging between them
// throughput: one word per cycle while out_tready stays high; the parse state updates once per word
// reset: rst_n synchronous, active low; empties both stages and returns the
// parser to the request line; depends on hrt_pkg, hrt_in_reg, hrt_parse, hrt_out_reg
module http_request_header_tokenizer
  import hrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] request_line_end, [9] pair_end, 0 pad
  output logic        out_tlast,  // header_end
  output logic [2:0]  out_tuser   // [2:0] token_kind
);

  logic       st_valid;
  logic [7:0] st_data;
  logic       advance;
  hrt_res_t   res;
  hrt_res_t   res_q;

  // word moves on when the result register is empty or being drained
  assign advance = st_valid && (!out_tvalid || out_tready);

  hrt_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .valid     (st_valid),
    .data      (st_data)
  );

  hrt_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .data    (st_data),
    .res     (res)
  );

  hrt_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_q      (res_q)
  );

  // output packing
  assign out_tdata = {6'd0, res_q.pair_end, res_q.line_end, res_q.data};
  assign out_tlast = res_q.header_end;
  assign out_tuser = res_q.kind;

  // flagged words are always delimiters
  a_flag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tlast || out_tdata[8] || out_tdata[9]) |-> out_tuser == KIND_NONE)
    else $error("flagged word carries a token kind");

  // at most one end marker per word
  a_flag_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tlast, out_tdata[8], out_tdata[9]}))
    else $error("several end markers on one word");

  // an empty result register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
